[rtl/core/spmq_pkg.sv]
package spmq_pkg;

	// operation codes carried in the func field
	localparam logic FUNC_SEND = 1'b0;
	localparam logic FUNC_RECV = 1'b1;

	// configuration register indexes
	localparam logic [1:0] REG_QUEUE_CAPACITY = 2'd0;
	localparam logic [1:0] REG_MAX_MSG_SIZE   = 2'd1;

	// register widths and reset values
	localparam int CAP_W  = 5;
	localparam int SIZE_W = 14;
	localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd10;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 14'd8192;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BAD_PRIO = 3'd1,
		ST_SIZE     = 3'd2,
		ST_FULL     = 3'd3,
		ST_EMPTY    = 3'd4
	} status_t;

	typedef struct packed {
		logic        func;
		logic [15:0] priority_req;
		logic [13:0] length;
		logic [31:0] payload_tag;
	} req_word_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] out_tag;
		logic [14:0] out_priority;
		logic [13:0] out_length;
		logic [4:0]  msg_count;
		logic        became_nonempty;
	} rsp_word_t;

	// shift command shared by every cell of the chain
	typedef struct packed {
		logic push;
		logic pop;
	} spmq_op_t;

endpackage

[rtl/core/spmq_cell.sv]
module spmq_cell #(
	parameter int PRIO_W = 15
) (
	input  logic                clk,
	input  spmq_pkg::spmq_op_t  op,
	input  logic                occ,
	input  logic                keep_prev,
	output logic                keep,
	input  logic [31:0]         new_tag,
	input  logic [13:0]         new_len,
	input  logic [PRIO_W-1:0]   new_prio,
	input  logic [31:0]         prev_tag,
	input  logic [13:0]         prev_len,
	input  logic [PRIO_W-1:0]   prev_prio,
	input  logic [31:0]         next_tag,
	input  logic [13:0]         next_len,
	input  logic [PRIO_W-1:0]   next_prio,
	output logic [31:0]         tag_q,
	output logic [13:0]         len_q,
	output logic [PRIO_W-1:0]   prio_q
);

	// an occupied entry of equal or higher priority stays ahead of a new word
	assign keep = occ && (prio_q >= new_prio);

	// insert: hold, take the new word at the boundary, or shift down from the neighbour
	// pop: shift up from the next cell
	always_ff @(posedge clk) begin
		if (op.push) begin
			if (!keep) begin
				if (keep_prev) begin
					tag_q  <= new_tag;
					len_q  <= new_len;
					prio_q <= new_prio;
				end else begin
					tag_q  <= prev_tag;
					len_q  <= prev_len;
					prio_q <= prev_prio;
				end
			end
		end else if (op.pop) begin
			tag_q  <= next_tag;
			len_q  <= next_len;
			prio_q <= next_prio;
		end
	end

endmodule

[rtl/core/stable_priority_message_queue_core.sv]
// the response is registered; a word accepted at one edge has its response valid from that edge on
// throughput: one word per cycle while responses are taken; the sorted cell chain inserts or pops in a single shift
// a response that is not taken holds off input; a new word enters in the cycle it is taken
// reset: message count cleared, capacity back to 10, size limit back to 8192
// reset: the cell chain keeps no reset; entries beyond the count are never read
module stable_priority_message_queue_core #(
	parameter int QUEUE_DEPTH = 16,
	parameter int PRIO_LEVELS = 32768,
	parameter int SIZE_LIMIT  = 8192
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  spmq_pkg::req_word_t   req,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output spmq_pkg::rsp_word_t   rsp,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [13:0]           cfg_data
);

	localparam int PRIO_W = (PRIO_LEVELS > 1) ? $clog2(PRIO_LEVELS) : 1;
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int CMP_W  = (CNT_W > spmq_pkg::CAP_W) ? CNT_W : spmq_pkg::CAP_W;

	logic [spmq_pkg::CAP_W-1:0]  queue_capacity_q;
	logic [spmq_pkg::SIZE_W-1:0] max_msg_size_q;
	logic [CNT_W-1:0]            held_q;
	logic                        rsp_valid_q;
	spmq_pkg::rsp_word_t         rsp_q;

	logic               accept;
	logic               is_send;
	logic [16:0]        eff_size;
	logic               prio_bad;
	logic               send_size_bad;
	logic               recv_size_bad;
	logic               full;
	logic               empty;
	logic               push_ok;
	logic               pop_ok;
	logic [CNT_W-1:0]   held_next;
	spmq_pkg::status_t  status;
	spmq_pkg::spmq_op_t op;
	logic [PRIO_W-1:0]  new_prio;
	logic [15:0]        head_prio16;
	spmq_pkg::rsp_word_t rsp_d;

	logic [31:0]       cell_tag  [QUEUE_DEPTH];
	logic [13:0]       cell_len  [QUEUE_DEPTH];
	logic [PRIO_W-1:0] cell_prio [QUEUE_DEPTH];
	logic              cell_keep [QUEUE_DEPTH];

	// handshake: the response register frees as it is taken
	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queue_capacity_q <= spmq_pkg::CAP_RESET;
			max_msg_size_q   <= spmq_pkg::SIZE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				spmq_pkg::REG_QUEUE_CAPACITY: queue_capacity_q <= cfg_data[spmq_pkg::CAP_W-1:0];
				spmq_pkg::REG_MAX_MSG_SIZE:   max_msg_size_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// admission checks
	assign is_send  = (req.func == spmq_pkg::FUNC_SEND);
	assign eff_size = (17'(max_msg_size_q) < 17'(SIZE_LIMIT)) ?
		17'(max_msg_size_q) : 17'(SIZE_LIMIT);
	assign prio_bad      = (17'(req.priority_req) >= 17'(PRIO_LEVELS));
	assign send_size_bad = (17'(req.length) > eff_size);
	assign recv_size_bad = (17'(req.length) < eff_size);
	assign full  = (CMP_W'(held_q) >= CMP_W'(queue_capacity_q)) ||
		(CMP_W'(held_q) >= CMP_W'(QUEUE_DEPTH));
	assign empty = (held_q == '0);

	always_comb begin
		status = spmq_pkg::ST_OK;
		if (is_send) begin
			if (prio_bad)           status = spmq_pkg::ST_BAD_PRIO;
			else if (send_size_bad) status = spmq_pkg::ST_SIZE;
			else if (full)          status = spmq_pkg::ST_FULL;
		end else begin
			if (recv_size_bad) status = spmq_pkg::ST_SIZE;
			else if (empty)    status = spmq_pkg::ST_EMPTY;
		end
	end

	assign push_ok = accept && is_send && (status == spmq_pkg::ST_OK);
	assign pop_ok  = accept && !is_send && (status == spmq_pkg::ST_OK);
	assign op.push = push_ok;
	assign op.pop  = pop_ok;
	assign new_prio = PRIO_W'(req.priority_req);

	// message count
	always_comb begin
		held_next = held_q;
		if (push_ok)     held_next = held_q + CNT_W'(1);
		else if (pop_ok) held_next = held_q - CNT_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) held_q <= '0;
		else         held_q <= held_next;
	end

	// sorted chain of cells, head at cell zero
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic              keep_prev;
		logic [31:0]       prev_tag;
		logic [13:0]       prev_len;
		logic [PRIO_W-1:0] prev_prio;
		logic [31:0]       next_tag;
		logic [13:0]       next_len;
		logic [PRIO_W-1:0] next_prio;

		if (i == 0) begin : g_head
			assign keep_prev = 1'b1;
			assign prev_tag  = req.payload_tag;
			assign prev_len  = req.length;
			assign prev_prio = new_prio;
		end else begin : g_body
			assign keep_prev = cell_keep[i-1];
			assign prev_tag  = cell_tag[i-1];
			assign prev_len  = cell_len[i-1];
			assign prev_prio = cell_prio[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign next_tag  = req.payload_tag;
			assign next_len  = req.length;
			assign next_prio = new_prio;
		end else begin : g_mid
			assign next_tag  = cell_tag[i+1];
			assign next_len  = cell_len[i+1];
			assign next_prio = cell_prio[i+1];
		end

		spmq_cell #(
			.PRIO_W(PRIO_W)
		) u_cell (
			.clk       (clk),
			.op        (op),
			.occ       (CNT_W'(i) < held_q),
			.keep_prev (keep_prev),
			.keep      (cell_keep[i]),
			.new_tag   (req.payload_tag),
			.new_len   (req.length),
			.new_prio  (new_prio),
			.prev_tag  (prev_tag),
			.prev_len  (prev_len),
			.prev_prio (prev_prio),
			.next_tag  (next_tag),
			.next_len  (next_len),
			.next_prio (next_prio),
			.tag_q     (cell_tag[i]),
			.len_q     (cell_len[i]),
			.prio_q    (cell_prio[i])
		);
	end

	// response word
	assign head_prio16 = 16'(cell_prio[0]);

	always_comb begin
		rsp_d                 = '0;
		rsp_d.status          = status;
		rsp_d.msg_count       = 5'(held_next);
		rsp_d.became_nonempty = push_ok && empty;
		if (pop_ok) begin
			rsp_d.out_tag      = cell_tag[0];
			rsp_d.out_priority = head_prio16[14:0];
			rsp_d.out_length   = cell_len[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) rsp_q <= rsp_d;
	end

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(held_q) <= CMP_W'(QUEUE_DEPTH))
		else $error("message count beyond depth");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		push_ok |=> (held_q == $past(held_q) + CNT_W'(1)))
		else $error("count did not grow on insert");

	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(CMP_W'(held_q) >= CMP_W'(2)) |-> (cell_prio[0] >= cell_prio[1]))
		else $error("head ranks below second entry");

	a_nonempty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.became_nonempty) |-> (rsp_q.msg_count == 5'd1))
		else $error("first insert does not leave one message");

endmodule

[test/spmq_queue_checker.sv]
`timescale 1ns / 100ps

module spmq_queue_checker
	import spmq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16,
	parameter int PRIO_LEVELS = 32768,
	parameter int SIZE_LIMIT  = 8192
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_ready,
	input  req_word_t   req,
	input  logic        rsp_valid,
	input  logic        rsp_ready,
	input  rsp_word_t   rsp,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [13:0] cfg_data,
	output int          fail_count,
	output int          pending
);

	// shadow of the sorted message store, head at entry 0
	logic [31:0]       tag_mem  [QUEUE_DEPTH];
	logic [15:0]       prio_mem [QUEUE_DEPTH];
	logic [13:0]       len_mem  [QUEUE_DEPTH];
	int                held;
	logic [CAP_W-1:0]  cap_reg;
	logic [SIZE_W-1:0] size_reg;
	rsp_word_t         queued_rsp[$];
	rsp_word_t         exp_w;

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	// apply one send or receive to the shadow store and build its response word
	function automatic rsp_word_t predict_queue_op(req_word_t w);
		rsp_word_t r;
		int        cap_eff;
		int        size_eff;
		int        pos;
		r        = '0;
		r.status = ST_OK;
		cap_eff  = (cap_reg < QUEUE_DEPTH) ? int'(cap_reg) : QUEUE_DEPTH;
		size_eff = (size_reg < SIZE_LIMIT) ? int'(size_reg) : SIZE_LIMIT;
		if (w.func == FUNC_SEND) begin
			if (int'(w.priority_req) >= PRIO_LEVELS) begin
				r.status = ST_BAD_PRIO;
			end else if (int'(w.length) > size_eff) begin
				r.status = ST_SIZE;
			end else if (held >= cap_eff) begin
				r.status = ST_FULL;
			end else begin
				// behind every held message of equal or higher priority
				pos = 0;
				while (pos < held && prio_mem[pos] >= w.priority_req)
					pos++;
				for (int i = held; i > pos; i--) begin
					tag_mem[i]  = tag_mem[i-1];
					prio_mem[i] = prio_mem[i-1];
					len_mem[i]  = len_mem[i-1];
				end
				tag_mem[pos]      = w.payload_tag;
				prio_mem[pos]     = w.priority_req;
				len_mem[pos]      = w.length;
				r.became_nonempty = (held == 0);
				held++;
			end
		end else begin
			if (int'(w.length) < size_eff) begin
				r.status = ST_SIZE;
			end else if (held == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.out_tag      = tag_mem[0];
				r.out_priority = prio_mem[0][14:0];
				r.out_length   = len_mem[0];
				for (int i = 0; i + 1 < held; i++) begin
					tag_mem[i]  = tag_mem[i+1];
					prio_mem[i] = prio_mem[i+1];
					len_mem[i]  = len_mem[i+1];
				end
				held--;
			end
		end
		r.msg_count = held[4:0];
		return r;
	endfunction

	// compare taken words, track register writes, predict accepted words
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held     = 0;
			cap_reg  = CAP_RESET;
			size_reg = SIZE_RESET;
			queued_rsp.delete();
			pending <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (queued_rsp.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: response word with none expected: status %0d tag %08h",
							$realtime, rsp.status, rsp.out_tag);
					fail_count <= fail_count + 1;
				end else begin
					exp_w = queued_rsp.pop_front();
					if (rsp.status !== exp_w.status || rsp.out_tag !== exp_w.out_tag ||
						rsp.out_priority !== exp_w.out_priority ||
						rsp.out_length !== exp_w.out_length ||
						rsp.msg_count !== exp_w.msg_count ||
						rsp.became_nonempty !== exp_w.became_nonempty) begin
						if (fail_count < 10) begin
							$display("%0t: mismatch, expected st %0d tag %08h pri %0d len %0d cnt %0d ne %0b",
								$realtime, exp_w.status, exp_w.out_tag, exp_w.out_priority,
								exp_w.out_length, exp_w.msg_count, exp_w.became_nonempty);
							$display("%0t:           got      st %0d tag %08h pri %0d len %0d cnt %0d ne %0b",
								$realtime, rsp.status, rsp.out_tag, rsp.out_priority,
								rsp.out_length, rsp.msg_count, rsp.became_nonempty);
						end
						fail_count <= fail_count + 1;
					end
				end
			end
			if (cfg_we) begin
				if (cfg_index == REG_QUEUE_CAPACITY)
					cap_reg = cfg_data[CAP_W-1:0];
				else if (cfg_index == REG_MAX_MSG_SIZE)
					size_reg = cfg_data;
			end
			if (req_valid && req_ready)
				queued_rsp.push_back(predict_queue_op(req));
			pending <= queued_rsp.size();
		end
	end

endmodule

[test/stable_priority_message_queue_core_test.sv]
`timescale 1ns / 100ps

module stable_priority_message_queue_core_test;
	import spmq_pkg::*;

	localparam int QUEUE_DEPTH = 16;
	localparam int PRIO_LEVELS = 32768;
	localparam int SIZE_LIMIT  = 8192;
	localparam int QUIET_LIMIT = 5000;
	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 163;

	// indexes past the last register, writes there must be dropped
	localparam logic [1:0] REG_SPARE_LO = 2'd2;
	localparam logic [1:0] REG_SPARE_HI = 2'd3;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	req_word_t   req       = '0;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	rsp_word_t   rsp;
	logic        cfg_we    = 1'b0;
	logic [1:0]  cfg_index = REG_QUEUE_CAPACITY;
	logic [13:0] cfg_data  = '0;

	int fail_count;
	int pending;
	int size_eff   = SIZE_LIMIT;
	int burst_left = 0;
	int quiet      = 0;
	int ready_mode = 0;
	int mode_left  = 0;
	int tick       = 0;

	always #4 clk = ~clk;

	stable_priority_message_queue_core #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.PRIO_LEVELS(PRIO_LEVELS),
		.SIZE_LIMIT (SIZE_LIMIT)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	spmq_queue_checker #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.PRIO_LEVELS(PRIO_LEVELS),
		.SIZE_LIMIT (SIZE_LIMIT)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fail_count(fail_count),
		.pending   (pending)
	);

	// receiver stalls, switching between its own patterns
	always @(posedge clk) begin
		if (mode_left == 0) begin
			ready_mode <= $urandom_range(3, 0);
			mode_left  <= $urandom_range(300, 30);
		end else begin
			mode_left <= mode_left - 1;
		end
		tick <= tick + 1;
		case (ready_mode)
			0: rsp_ready <= 1'b1;
			1: rsp_ready <= 1'($urandom_range(1, 0));
			2: rsp_ready <= ($urandom_range(3, 0) == 0);
			default: rsp_ready <= (tick % 7) < 4;
		endcase
	end

	// give up when nothing moves for too long
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || cfg_we) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	function automatic req_word_t make_word(logic f, logic [15:0] p, logic [13:0] l,
		logic [31:0] t);
		req_word_t w;
		w.func         = f;
		w.priority_req = p;
		w.length       = l;
		w.payload_tag  = t;
		return w;
	endfunction

	// offer one word, with bursts and random gaps between them
	task automatic send_word(input req_word_t w);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
			if (gap != 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(150, 40)
				: $urandom_range(20, 1);
		end
		req       <= w;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		burst_left--;
	endtask

	// stop sending and wait for every response word to be taken
	task automatic wait_idle();
		req_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (2) @(posedge clk);
		burst_left = 0;
	endtask

	// write both registers, plus one write to an unused index
	task automatic set_config(input logic [4:0] cap, input logic [13:0] size);
		logic [8:0] junk;
		junk      = 9'($urandom);
		cfg_we    <= 1'b1;
		cfg_index <= REG_QUEUE_CAPACITY;
		cfg_data  <= {junk, cap};
		@(posedge clk);
		cfg_index <= REG_MAX_MSG_SIZE;
		cfg_data  <= size;
		@(posedge clk);
		cfg_index <= ($urandom_range(1, 0) != 0) ? REG_SPARE_LO : REG_SPARE_HI;
		cfg_data  <= 14'($urandom);
		@(posedge clk);
		cfg_we   <= 1'b0;
		size_eff = (size > SIZE_LIMIT) ? SIZE_LIMIT : int'(size);
	endtask

	// mostly legal sends and receives, filling then draining, with some noise
	task automatic random_items(input int n);
		int          pick;
		int          send_pct;
		logic [15:0] p;
		logic [13:0] l;
		for (int i = 0; i < n; i++) begin
			send_pct = (i < n / 2) ? 70 : 30;
			pick     = $urandom_range(99, 0);
			if (pick < 10) begin
				send_word(make_word(1'($urandom_range(1, 0)), 16'($urandom), 14'($urandom),
					$urandom));
			end else if (pick < 10 + send_pct) begin
				case ($urandom_range(3, 0))
					0: p = 16'($urandom_range(3, 0));
					1: p = 16'(PRIO_LEVELS - 1 - int'($urandom_range(1, 0)));
					2: p = 16'($urandom_range(40, 0) * 800);
					default: p = 16'($urandom_range(PRIO_LEVELS - 1, 0));
				endcase
				l = ($urandom_range(9, 0) == 0) ? 14'(size_eff)
					: 14'($urandom_range(size_eff, 0));
				send_word(make_word(FUNC_SEND, p, l, $urandom));
			end else begin
				l = ($urandom_range(9, 0) == 0) ? 14'(size_eff)
					: 14'($urandom_range(16383, size_eff));
				send_word(make_word(FUNC_RECV, 16'($urandom), l, $urandom));
			end
		end
	endtask

	initial begin
		logic [4:0]  cap;
		logic [13:0] size;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed words on the reset settings
		send_word(make_word(FUNC_RECV, 16'h0000, 14'd8192, 32'h0000_0000));
		send_word(make_word(FUNC_RECV, 16'hffff, 14'd8191, 32'hffff_ffff));
		send_word(make_word(FUNC_RECV, 16'h0000, 14'd0, 32'h0000_0000));
		send_word(make_word(FUNC_SEND, 16'h8000, 14'd0, 32'h1234_5678));
		// priority is checked before size
		send_word(make_word(FUNC_SEND, 16'hffff, 14'd16383, 32'hffff_ffff));
		send_word(make_word(FUNC_SEND, 16'h0000, 14'd8193, 32'h0000_0001));
		send_word(make_word(FUNC_SEND, 16'h0000, 14'd0, 32'h0000_0000));
		send_word(make_word(FUNC_SEND, 16'h7fff, 14'd8192, 32'hffff_ffff));
		// equal priorities must keep arrival order
		send_word(make_word(FUNC_SEND, 16'd5, 14'd17, 32'ha5a5_a5a5));
		send_word(make_word(FUNC_SEND, 16'd5, 14'd18, 32'h5a5a_5a5a));
		repeat (6)
			send_word(make_word(FUNC_SEND, 16'($urandom_range(7, 0)),
				14'($urandom_range(8192, 0)), $urandom));
		// queue now full: size and priority errors still win over full
		send_word(make_word(FUNC_SEND, 16'd1, 14'd16383, 32'hdead_beef));
		send_word(make_word(FUNC_SEND, 16'h8000, 14'd1, 32'hcafe_f00d));
		send_word(make_word(FUNC_SEND, 16'd3, 14'd4, 32'h0bad_cafe));
		wait_idle();

		// phases over register settings, extremes first
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin cap = 5'd0;  size = 14'd0;     end
				1: begin cap = 5'd1;  size = 14'd1;     end
				2: begin cap = 5'd16; size = 14'd8192;  end
				3: begin cap = 5'd31; size = 14'd16383; end
				4: begin cap = 5'd16; size = 14'd0;     end
				5: begin cap = 5'd2;  size = 14'd100;   end
				6: begin cap = 5'd5;  size = 14'd8191;  end
				7: begin
					cap  = 5'($urandom_range(31, 0));
					size = 14'($urandom_range(8192, 1));
				end
				8: begin
					cap  = 5'($urandom_range(31, 0));
					size = 14'($urandom_range(16383, 0));
				end
				default: begin cap = 5'd16; size = 14'd8192; end
			endcase
			set_config(cap, size);
			random_items(PHASE_ITEMS);
			wait_idle();
		end

		repeat (4) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
